[rtl/core/spcf_pkg.sv]
// package: shared types and constants of the strip pedestal cluster finder
package spcf_pkg;

   typedef struct packed {
      logic        cmd;
      logic [6:0]  channel;
      logic [15:0] sample;
      logic        end_of_event;
   } req_type;

   typedef struct packed {
      logic        cluster_valid;
      logic [6:0]  seed_channel;
      logic [22:0] charge;
      logic [7:0]  width;
      logic [14:0] centroid;
      logic        last_cluster;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN_ADDR,
      ST_SCAN_TEST,
      ST_LEFT_ADDR,
      ST_LEFT_TEST,
      ST_RIGHT_ADDR,
      ST_RIGHT_TEST,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_PUSH,
      ST_LAST
   } state_type;

   localparam logic CMD_CALIB   = 1'b0;
   localparam logic CMD_PHYSICS = 1'b1;

   localparam logic CSR_HIGH_THRESHOLD = 1'b0;
   localparam logic CSR_LOW_THRESHOLD  = 1'b1;

   localparam int CHARGE_W   = 23;
   localparam int WIDTH_W    = 8;
   localparam int CENTROID_W = 15;
   localparam int CENTROID_MAX = 32767;
   localparam int MAX_RESULTS  = 64;
   localparam int RES_CNT_W    = 7;

endpackage

[rtl/core/spcf_ram.sv]
// generic single-write, single-read ram with registered read data
module spcf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/strip_pedestal_cluster_finder_unit.sv]
// top level: pedestal calibration, sample storage and sequential cluster scan
//
//  channel | direction | ports                          | payload
//  req     | in        | req_valid, req_stall, req_data | spcf_pkg::req_type
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data | spcf_pkg::rsp_type
//  csr     | in        | csr_we, csr_index, csr_wdata   | 16-bit threshold
//
// a calibration item or a physics item that does not end its event takes a pedestal ram read,
// then an update; the final physics item of an event starts the scan: each channel is read
// and tested, each neighbor walked is read and tested, the shared divider runs once per
// cluster, and each result transaction waits until the output is free
// reset is synchronous; pedestal entries carry valid bits that reset clears at once,
// so no clearing pass is needed; sample storage is not cleared
// req_stall is high whenever the sequencer is busy; rsp_stall holds the pending result
module strip_pedestal_cluster_finder_unit #(
   parameter int NUM_CHANNELS      = 128,
   parameter int CALIB_EVENTS_LOG2 = 10,
   parameter int SAMPLE_BITS       = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spcf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spcf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PS_W   = SAMPLE_BITS + CALIB_EVENTS_LOG2 + 1;
   localparam int SUM_W  = SAMPLE_BITS + $clog2(NUM_CHANNELS + 1);
   localparam int MOM_W  = SUM_W + CH_W;
   localparam int DVD_W  = MOM_W + 8;
   localparam int DCNT_W = $clog2(DVD_W + 1);
   localparam int W_W    = $clog2(NUM_CHANNELS + 1);
   localparam int CNT_W  = CALIB_EVENTS_LOG2 + 1;
   localparam int PROD_W = SAMPLE_BITS + CH_W;
   localparam int CS_W   = (SUM_W > spcf_pkg::CHARGE_W) ? SUM_W : spcf_pkg::CHARGE_W;
   localparam int WS_W   = (W_W > spcf_pkg::WIDTH_W) ? W_W : spcf_pkg::WIDTH_W;
   localparam logic [CH_W-1:0]  LAST_CH    = CH_W'(NUM_CHANNELS - 1);
   localparam logic [CNT_W-1:0] CALIB_DONE = CNT_W'(1) << CALIB_EVENTS_LOG2;

   // control state
   spcf_pkg::state_type state_ff, state_in;
   logic [15:0]             hi_thr_ff, lo_thr_ff;
   logic [CNT_W-1:0]        calib_cnt_ff, calib_cnt_in;
   logic [NUM_CHANNELS-1:0] pvalid_ff, pvalid_in;
   logic                    prev_seed_ff, prev_seed_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [spcf_pkg::RES_CNT_W-1:0] nres_ff, nres_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;

   // datapath registers
   spcf_pkg::req_type       req_ff;
   logic [CH_W-1:0]         j_ff, j_in;
   logic [CH_W-1:0]         c_ff, c_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [MOM_W-1:0]        mom_ff, mom_in;
   logic [W_W-1:0]          w_ff, w_in;
   logic [DVD_W-1:0]        dvd_ff, dvd_in;
   logic [SUM_W:0]          rem_ff, rem_in;
   spcf_pkg::rsp_type       res_ff, res_in;
   spcf_pkg::rsp_type       pend_ff, pend_in;

   // memories
   logic                    ped_we;
   logic [CH_W-1:0]         ped_waddr, ped_raddr;
   logic [PS_W-1:0]         ped_wdata, ped_rd;
   logic                    evt_we;
   logic [CH_W-1:0]         evt_raddr;
   logic [SAMPLE_BITS-1:0]  evt_wdata, evt_rd;

   spcf_ram #(.WIDTH(PS_W), .DEPTH(NUM_CHANNELS)) u_ped_ram (
      .clock   (clock),
      .wr_en   (ped_we),
      .wr_addr (ped_waddr),
      .wr_data (ped_wdata),
      .rd_addr (ped_raddr),
      .rd_data (ped_rd)
   );

   spcf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_CHANNELS)) u_evt_ram (
      .clock   (clock),
      .wr_en   (evt_we),
      .wr_addr (ped_waddr),
      .wr_data (evt_wdata),
      .rd_addr (evt_raddr),
      .rd_data (evt_rd)
   );

   // combinational helpers
   logic                   in_range;
   logic [SAMPLE_BITS-1:0] smp;
   logic [PS_W-1:0]        ped_cur, ped_shift, smp_ext;
   logic [PS_W:0]          ped_add;
   logic [CH_W-1:0]        mul_ch;
   logic [PROD_W-1:0]      prod;
   logic [SUM_W:0]         trial;
   logic                   qbit;
   logic [CS_W-1:0]        charge_ext;
   logic [WS_W-1:0]        width_ext;

   assign ped_waddr = CH_W'(req_ff.channel);
   assign in_range  = 32'(req_ff.channel) < 32'(NUM_CHANNELS);
   assign smp       = req_ff.sample[SAMPLE_BITS-1:0];
   assign smp_ext   = PS_W'(smp);
   assign ped_cur   = pvalid_ff[ped_waddr] ? ped_rd : '0;
   assign ped_add   = {1'b0, ped_cur} + {1'b0, smp_ext};
   assign ped_shift = ped_cur >> CALIB_EVENTS_LOG2;
   assign ped_wdata = ped_add[PS_W] ? '1 : ped_add[PS_W-1:0];
   assign evt_wdata = (smp_ext > ped_shift) ? SAMPLE_BITS'(smp_ext - ped_shift) : '0;
   assign ped_raddr = CH_W'(req_data.channel);
   assign evt_raddr = (state_ff == spcf_pkg::ST_SCAN_ADDR) ? j_ff : c_ff;

   // shared multiplier: sample value times its channel index
   assign mul_ch = (state_ff == spcf_pkg::ST_SCAN_TEST) ? j_ff : c_ff;
   assign prod   = PROD_W'(evt_rd) * PROD_W'(mul_ch);

   // one restoring step of the centroid divider
   assign trial = {rem_ff[SUM_W-1:0], dvd_ff[DVD_W-1]};
   assign qbit  = trial >= {1'b0, sum_ff};

   assign charge_ext = CS_W'(sum_ff);
   assign width_ext  = WS_W'(w_ff);

   // handshake and payload
   assign req_stall = state_ff != spcf_pkg::ST_IDLE;
   assign rsp_valid = (state_ff == spcf_pkg::ST_LAST) ||
                      ((state_ff == spcf_pkg::ST_PUSH) && pend_valid_ff);

   always_comb begin
      rsp_data               = pend_ff;
      rsp_data.cluster_valid = pend_valid_ff;
      rsp_data.last_cluster  = state_ff == spcf_pkg::ST_LAST;
      if (!pend_valid_ff) begin
         rsp_data.seed_channel = '0;
         rsp_data.charge       = '0;
         rsp_data.width        = '0;
         rsp_data.centroid     = '0;
      end
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_thr_ff <= 16'd30;
         lo_thr_ff <= 16'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            spcf_pkg::CSR_HIGH_THRESHOLD: hi_thr_ff <= csr_wdata;
            spcf_pkg::CSR_LOW_THRESHOLD:  lo_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spcf_pkg::ST_IDLE;
         calib_cnt_ff  <= '0;
         pvalid_ff     <= '0;
         prev_seed_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         nres_ff       <= '0;
         dcnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         calib_cnt_ff  <= calib_cnt_in;
         pvalid_ff     <= pvalid_in;
         prev_seed_ff  <= prev_seed_in;
         pend_valid_ff <= pend_valid_in;
         nres_ff       <= nres_in;
         dcnt_ff       <= dcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == spcf_pkg::ST_IDLE) begin
         req_ff <= req_data;
      end
      j_ff    <= j_in;
      c_ff    <= c_in;
      sum_ff  <= sum_in;
      mom_ff  <= mom_in;
      w_ff    <= w_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      calib_cnt_in  = calib_cnt_ff;
      pvalid_in     = pvalid_ff;
      prev_seed_in  = prev_seed_ff;
      pend_valid_in = pend_valid_ff;
      nres_in       = nres_ff;
      dcnt_in       = dcnt_ff;
      j_in          = j_ff;
      c_in          = c_ff;
      sum_in        = sum_ff;
      mom_in        = mom_ff;
      w_in          = w_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      ped_we        = 1'b0;
      evt_we        = 1'b0;

      unique case (state_ff)
         spcf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = spcf_pkg::ST_APPLY;
            end
         end

         spcf_pkg::ST_APPLY: begin
            state_in = spcf_pkg::ST_IDLE;
            if (req_ff.cmd == spcf_pkg::CMD_CALIB) begin
               // calibration ends after the programmed number of events
               if (calib_cnt_ff < CALIB_DONE) begin
                  if (in_range) begin
                     ped_we               = 1'b1;
                     pvalid_in[ped_waddr] = 1'b1;
                  end
                  if (req_ff.end_of_event) begin
                     calib_cnt_in = calib_cnt_ff + 1'b1;
                  end
               end
            end else begin
               evt_we = in_range;
               if (req_ff.end_of_event) begin
                  state_in      = spcf_pkg::ST_SCAN_ADDR;
                  j_in          = '0;
                  prev_seed_in  = 1'b0;
                  nres_in       = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end

         spcf_pkg::ST_SCAN_ADDR: begin
            state_in = spcf_pkg::ST_SCAN_TEST;
         end

         spcf_pkg::ST_SCAN_TEST: begin
            prev_seed_in = (16'(evt_rd) > hi_thr_ff) && !prev_seed_ff;
            if (prev_seed_in && (32'(nres_ff) < spcf_pkg::MAX_RESULTS)) begin
               // new seed: start the cluster with the seed itself
               nres_in = nres_ff + 1'b1;
               sum_in  = SUM_W'(evt_rd);
               mom_in  = MOM_W'(prod);
               w_in    = W_W'(1);
               if (j_ff != '0) begin
                  c_in     = j_ff - 1'b1;
                  state_in = spcf_pkg::ST_LEFT_ADDR;
               end else if (j_ff != LAST_CH) begin
                  c_in     = j_ff + 1'b1;
                  state_in = spcf_pkg::ST_RIGHT_ADDR;
               end else begin
                  state_in = spcf_pkg::ST_DIV_INIT;
               end
            end else if (j_ff == LAST_CH) begin
               state_in = spcf_pkg::ST_LAST;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = spcf_pkg::ST_SCAN_ADDR;
            end
         end

         spcf_pkg::ST_LEFT_ADDR: begin
            state_in = spcf_pkg::ST_LEFT_TEST;
         end

         spcf_pkg::ST_LEFT_TEST: begin
            if ((16'(evt_rd) > lo_thr_ff) && (c_ff != '0)) begin
               sum_in   = sum_ff + SUM_W'(evt_rd);
               mom_in   = mom_ff + MOM_W'(prod);
               w_in     = w_ff + 1'b1;
               c_in     = c_ff - 1'b1;
               state_in = spcf_pkg::ST_LEFT_ADDR;
            end else begin
               if (16'(evt_rd) > lo_thr_ff) begin
                  // channel zero joins, left edge reached
                  sum_in = sum_ff + SUM_W'(evt_rd);
                  mom_in = mom_ff + MOM_W'(prod);
                  w_in   = w_ff + 1'b1;
               end
               if (j_ff != LAST_CH) begin
                  c_in     = j_ff + 1'b1;
                  state_in = spcf_pkg::ST_RIGHT_ADDR;
               end else begin
                  state_in = spcf_pkg::ST_DIV_INIT;
               end
            end
         end

         spcf_pkg::ST_RIGHT_ADDR: begin
            state_in = spcf_pkg::ST_RIGHT_TEST;
         end

         spcf_pkg::ST_RIGHT_TEST: begin
            state_in = spcf_pkg::ST_DIV_INIT;
            if (16'(evt_rd) > lo_thr_ff) begin
               sum_in = sum_ff + SUM_W'(evt_rd);
               mom_in = mom_ff + MOM_W'(prod);
               w_in   = w_ff + 1'b1;
               if (c_ff != LAST_CH) begin
                  c_in     = c_ff + 1'b1;
                  state_in = spcf_pkg::ST_RIGHT_ADDR;
               end
            end
         end

         spcf_pkg::ST_DIV_INIT: begin
            dvd_in   = {mom_ff, 8'd0};
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = spcf_pkg::ST_DIV_STEP;
         end

         spcf_pkg::ST_DIV_STEP: begin
            rem_in  = qbit ? (trial - {1'b0, sum_ff}) : trial;
            dvd_in  = {dvd_ff[DVD_W-2:0], qbit};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DVD_W - 1)) begin
               // quotient complete: saturate and build the result
               res_in.cluster_valid = 1'b1;
               res_in.seed_channel  = 7'(j_ff);
               res_in.charge = (charge_ext > CS_W'({spcf_pkg::CHARGE_W{1'b1}})) ?
                               '1 : spcf_pkg::CHARGE_W'(charge_ext);
               res_in.width  = (width_ext > WS_W'({spcf_pkg::WIDTH_W{1'b1}})) ?
                               '1 : spcf_pkg::WIDTH_W'(width_ext);
               if (sum_ff == '0) begin
                  res_in.centroid = '0;
               end else if (dvd_in > DVD_W'(spcf_pkg::CENTROID_MAX)) begin
                  res_in.centroid = '1;
               end else begin
                  res_in.centroid = spcf_pkg::CENTROID_W'(dvd_in);
               end
               res_in.last_cluster = 1'b0;
               state_in = spcf_pkg::ST_PUSH;
            end
         end

         spcf_pkg::ST_PUSH: begin
            // older cluster goes out first, new one waits to learn if it is last
            if (!pend_valid_ff || !rsp_stall) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               if (j_ff == LAST_CH) begin
                  state_in = spcf_pkg::ST_LAST;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = spcf_pkg::ST_SCAN_ADDR;
               end
            end
         end

         spcf_pkg::ST_LAST: begin
            if (!rsp_stall) begin
               pend_valid_in = 1'b0;
               state_in      = spcf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = spcf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[verif/testbench.sv]
// testbench: random and directed stimulus with a self-checking cluster predictor
`timescale 1ns / 1ps

module testbench;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   spcf_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   spcf_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic              csr_index;
   logic [15:0]       csr_wdata;

   strip_pedestal_cluster_finder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int N_CH = 128;
   localparam int CAL_LOG2 = 10;

   // predictor copy of the block state
   longint      ped_sum [N_CH];
   int          cal_events;
   int unsigned strip_val [N_CH];
   int unsigned hi_thr;
   int unsigned lo_thr;

   spcf_pkg::req_type pending_q [$];
   spcf_pkg::rsp_type cluster_q [$];

   int errors;
   int n_items;
   int n_clusters;
   int n_empty;
   int burst_left;
   int gap_left;
   int hold_ask;
   int hold_done;
   int hold_left;
   int stall_mode;
   int mode_left;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // cluster search over the stored strips, appending expected results
   task automatic find_clusters();
      bit      prev_seed;
      bit      is_seed;
      int      n;
      longint  sum;
      longint  mom;
      longint  w;
      longint  cent;
      int      c;
      spcf_pkg::rsp_type r;
      prev_seed = 0;
      n = 0;
      for (int j = 0; j < N_CH; j++) begin
         is_seed = (strip_val[j] > hi_thr) && !prev_seed;
         prev_seed = is_seed;
         if (is_seed && n < spcf_pkg::MAX_RESULTS) begin
            sum = strip_val[j];
            mom = longint'(strip_val[j]) * j;
            w = 1;
            c = j - 1;
            while (c >= 0 && strip_val[c] > lo_thr) begin
               sum += strip_val[c]; mom += longint'(strip_val[c]) * c; w++; c--;
            end
            c = j + 1;
            while (c < N_CH && strip_val[c] > lo_thr) begin
               sum += strip_val[c]; mom += longint'(strip_val[c]) * c; w++; c++;
            end
            cent = (sum != 0) ? (mom * 256) / sum : 0;
            if (cent > spcf_pkg::CENTROID_MAX) cent = spcf_pkg::CENTROID_MAX;
            if (sum > 64'h7FFFFF) sum = 64'h7FFFFF;
            if (w > 255) w = 255;
            r = '0;
            r.cluster_valid = 1'b1;
            r.seed_channel = j[6:0];
            r.charge = sum[22:0];
            r.width = w[7:0];
            r.centroid = cent[14:0];
            cluster_q.insert(cluster_q.size(), r);
            n++;
         end
      end
      if (n == 0) begin
         r = '0;
         r.last_cluster = 1'b1;
         cluster_q.insert(cluster_q.size(), r);
      end else begin
         cluster_q[cluster_q.size() - 1].last_cluster = 1'b1;
      end
   endtask

   task automatic apply_sample(spcf_pkg::req_type t);
      longint ped;
      if (t.cmd == spcf_pkg::CMD_CALIB) begin
         // calibration stops counting once the full set of events is in
         if (cal_events < (1 << CAL_LOG2)) begin
            ped_sum[t.channel] += t.sample;
            if (t.end_of_event) cal_events++;
         end
      end else begin
         ped = ped_sum[t.channel] >> CAL_LOG2;
         strip_val[t.channel] = (longint'(t.sample) > ped) ? t.sample - ped : 0;
         if (t.end_of_event) find_clusters();
      end
   endtask

   // driver: bursts of transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left = 4;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_sample(req_data);
            n_items++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, longint expv, longint actv);
      if (expv != actv) begin
         $error("%s expected %0d actual %0d", name, expv, actv);
         errors++;
      end
   endtask

   // monitor: compare each result transaction, drive the stall pattern
   always @(posedge clock) begin
      spcf_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         stall_mode = 0;
         mode_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cluster_q.size() == 0) begin
               $error("result transaction with nothing expected");
               errors++;
            end else begin
               e = cluster_q.pop_front();
               check_field("cluster_valid", e.cluster_valid, rsp_data.cluster_valid);
               check_field("seed_channel", e.seed_channel, rsp_data.seed_channel);
               check_field("charge", e.charge, rsp_data.charge);
               check_field("width", e.width, rsp_data.width);
               check_field("centroid", e.centroid, rsp_data.centroid);
               check_field("last_cluster", e.last_cluster, rsp_data.last_cluster);
               if (e.cluster_valid) n_clusters++; else n_empty++;
            end
         end
         if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            hold_left = 3000;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            unique case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 4);
               default: rsp_stall <= mode_left[0];
            endcase
         end
      end
   end

   task automatic push_sample(logic cmd, int ch, int smp, bit eoe);
      spcf_pkg::req_type t;
      t.cmd = cmd;
      t.channel = ch[6:0];
      t.sample = smp[15:0];
      t.end_of_event = eoe;
      pending_q.insert(pending_q.size(), t);
   endtask

   // let the block drain: all sent, all results seen, then a short margin
   task automatic drain();
      while (pending_q.size() > 0 || req_valid) @(posedge clock);
      while (cluster_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_thr(logic idx, int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == spcf_pkg::CSR_HIGH_THRESHOLD) hi_thr = val[15:0]; else lo_thr = val[15:0];
   endtask

   // physics event on one to four adjacent strips with random content, calibration items mixed in
   task automatic random_event();
      int n;
      int base;
      int amp;
      n = $urandom_range(1, 4);
      base = $urandom_range(0, N_CH - 1);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 5))
            0: amp = $urandom_range(0, 65535);
            1: amp = 65535;
            2: amp = $urandom_range(0, 20);
            default: amp = $urandom_range(0, 600);
         endcase
         if ($urandom_range(0, 4) == 0) push_sample(spcf_pkg::CMD_CALIB,
                                                    $urandom_range(0, 127),
                                                    $urandom_range(0, 65535), 0);
         push_sample(spcf_pkg::CMD_PHYSICS, (base + k) % N_CH, amp, k == n - 1);
      end
   endtask

   initial begin
      int hi_set [5];
      int lo_set [5];
      errors = 0; n_items = 0; n_clusters = 0; n_empty = 0;
      hold_ask = 0; hold_done = 0;
      for (int i = 0; i < N_CH; i++) begin
         ped_sum[i] = 0; strip_val[i] = 0;
      end
      cal_events = 0;
      hi_thr = 30; lo_thr = 10;
      req_valid = 1'b0; req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0; csr_index = 1'b0; csr_wdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // a few calibration events with full-scale, zero and small samples
      push_sample(spcf_pkg::CMD_CALIB, 5, 65535, 1);
      push_sample(spcf_pkg::CMD_CALIB, 0, 0, 0);
      push_sample(spcf_pkg::CMD_CALIB, 127, 40, 1);
      // first physics event writes every strip, using the partial pedestal
      for (int i = 0; i < N_CH; i++)
         push_sample(spcf_pkg::CMD_PHYSICS, i,
                     (i % 17 == 3) ? 200 : ((i % 17 == 4) ? 25 : 3), i == N_CH - 1);
      push_sample(spcf_pkg::CMD_PHYSICS, 60, 65535, 1);
      push_sample(spcf_pkg::CMD_PHYSICS, 61, 0, 1);
      drain();

      // more calibration with full-scale samples, then a physics hit on that strip
      push_sample(spcf_pkg::CMD_CALIB, 10, 65535, 1);
      push_sample(spcf_pkg::CMD_CALIB, 11, 65535, 0);
      push_sample(spcf_pkg::CMD_PHYSICS, 10, 500, 1);
      drain();

      // zero thresholds over the stored strips: many results, wide clusters
      write_thr(spcf_pkg::CSR_HIGH_THRESHOLD, 0);
      write_thr(spcf_pkg::CSR_LOW_THRESHOLD, 0);
      push_sample(spcf_pkg::CMD_PHYSICS, 0, 65535, 1);
      drain();
      // nothing reaches the top threshold: empty event
      write_thr(spcf_pkg::CSR_HIGH_THRESHOLD, 65535);
      write_thr(spcf_pkg::CSR_LOW_THRESHOLD, 65535);
      push_sample(spcf_pkg::CMD_PHYSICS, 0, 65535, 1);
      drain();

      hi_set = '{30, 0, 65535, 120, 400};
      lo_set = '{10, 0, 65535, 25, 0};
      for (int p = 0; p < 5; p++) begin
         write_thr(spcf_pkg::CSR_HIGH_THRESHOLD, hi_set[p]);
         write_thr(spcf_pkg::CSR_LOW_THRESHOLD, lo_set[p]);
         for (int k = 0; k < ((p == 3) ? 2 : 1); k++) random_event();
         // long receiver hold while the sender keeps offering
         if (p == 3) hold_ask++;
         drain();
      end

      $display("covered %0d input transactions, %0d clusters and %0d empty events",
               n_items, n_clusters, n_empty);
      $display("threshold settings included zero, full scale and mid values");
      if (errors == 0 && cluster_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
